@@ src/rc_unpk_pkg.sv @@
// constants, types and helper functions for the rc frame crc channel unpacker
`default_nettype none
package rc_unpk_pkg;

	localparam int FRAME_BYTES   = 45;
	localparam int CHANNEL_COUNT = 16;
	localparam int POS_W         = 6;
	localparam int CHAN_W        = 4;
	localparam int VAL_W         = 12;
	localparam int STAGE_DEPTH   = 28;
	localparam int STG_ENTRIES   = 2 * STAGE_DEPTH;
	localparam int STG_AW        = 6;

	localparam logic [POS_W-1:0] LAST_IDX        = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] CTRL_HEAD_POS   = 6'd0;
	localparam logic [POS_W-1:0] CTRL_LEN_POS    = 6'd1;
	localparam logic [POS_W-1:0] CTRL_RSV_POS    = 6'd2;
	localparam logic [POS_W-1:0] CTRL_ID_POS     = 6'd3;
	localparam logic [POS_W-1:0] CTRL_FLG_POS    = 6'd28;
	localparam logic [POS_W-1:0] CTRL_CRC_HI_POS = 6'd29;
	localparam logic [POS_W-1:0] CTRL_CRC_LO_POS = 6'd30;
	localparam logic [POS_W-1:0] STAT_HEAD_POS   = 6'd31;
	localparam logic [POS_W-1:0] STAT_LEN_POS    = 6'd32;
	localparam logic [POS_W-1:0] RSSI_POS        = 6'd35;
	localparam logic [POS_W-1:0] STAT_CRC_HI_POS = 6'd43;
	localparam logic [POS_W-1:0] STAT_CRC_LO_POS = 6'd44;
	localparam logic [POS_W-1:0] STG_LAST_POS    = POS_W'(STAGE_DEPTH);

	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [7:0]  SYNC_RESET   = 8'h66;
	localparam logic [7:0]  LEN_RESET    = 8'd25;
	localparam logic [7:0]  RSV_RESET    = 8'd0;
	localparam logic [7:0]  ID_RESET     = 8'd176;
	localparam logic [7:0]  FLG_RESET    = 8'd0;
	localparam logic [7:0]  RSSI_RESET   = 8'd100;
	localparam logic [8:0]  CTRL_SPAN_OFS = 9'd2;
	localparam logic [8:0]  STAT_SPAN_OFS = 9'd33;

	typedef logic [CHAN_W-1:0] chan_idx_t;
	typedef logic [VAL_W-1:0]  chan_val_t;

	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ acc[7:0];
		t = t ^ (t << 4);
		return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
	endfunction

	function automatic chan_val_t chan_reset_value(input chan_idx_t k);
		chan_val_t v;
		v = 12'd0;
		if (k < 4'd8) begin
			v = 12'd1500;
		end else if (k < 4'd12) begin
			v = 12'd1000;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

@@ src/rc_frame_crc_channel_unpacker_unit.sv @@
// rc frame decoder: crc-checked sub-frames, channel store memory and channel result stream
// output: after the last frame byte's transfer, the emission control, read stage and output register
//   pass one channel result per cycle, 16 results in all, while the output side takes them
// throughput: one input byte per cycle; a byte arriving at the last frame position waits
//   only while the previous frame's channel reads are still pending or in the read stage
// reset: control state and channel-memory valid bits clear at once, no clearing pass
`default_nettype none
module rc_frame_crc_channel_unpacker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,        // sync_value
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,    // data_byte
	input  wire logic        s_axis_tuser,    // frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// channel_index, channel_value, control_ok, status_ok, flag_bits, data_ident,
	// length_value, reserved_value, signal_strength, zero fill
	output logic [63:0]      m_axis_tdata,
	output logic             m_axis_tlast
);
	import rc_unpk_pkg::*;

	// configuration
	logic [7:0] sync_q;

	// frame reception state
	logic [POS_W-1:0] pos_q;
	logic [15:0] ccrc_q, scrc_q;
	logic [7:0]  cspan_q, sspan_q;
	logic [1:0]  hm_q;
	logic [15:0] rcw0_q, rcw1_q;
	logic [7:0]  pend_len_q, pend_rsv_q, pend_id_q, pend_flg_q, pend_rssi_q;
	logic        wr_bank_q;

	// held values
	logic [7:0]  held_len_q, held_rsv_q, held_id_q, held_flg_q, held_rssi_q;

	// emission control
	logic        emit_act_q;
	chan_idx_t   emit_idx_q;
	logic        emit_bank_q;
	logic        emit_cok_q, emit_sok_q;

	// memories
	logic [7:0]  stg_mem [0:STG_ENTRIES-1];
	chan_val_t   chan_mem [0:CHANNEL_COUNT-1];
	logic [CHANNEL_COUNT-1:0] chan_vld_q;

	// read stage
	logic        s1_vld_s1;
	chan_idx_t   s1_idx_s1;
	logic [7:0]  stg_a_s1, stg_b_s1;
	chan_val_t   chan_rd_s1;
	logic        chan_init_s1;

	// output register
	logic        out_vld_q;
	chan_idx_t   out_idx_q;
	chan_val_t   out_val_q;
	logic        out_cok_q, out_sok_q, out_last_q;
	logic [7:0]  out_flg_q, out_id_q, out_len_q, out_rsv_q, out_rssi_q;

	// combinational
	logic             take, fin, busy, advance, issue, s1_mv, chan_wr;
	logic [POS_W-1:0] idx;
	logic [7:0]       b;
	logic [15:0]      ccrc_b, scrc_b, ccrc_n, scrc_n, rcw0_n, rcw1_n;
	logic [7:0]       cspan_n, sspan_n;
	logic [1:0]       hm_n;
	logic             c_ok, s_ok;
	logic [STG_AW-1:0] wr_addr, rd_a, rd_b, bank_ofs;
	logic [2:0]       pair;
	chan_val_t        unpacked, s1_val;

	assign cfg_ready     = 1'b1;
	assign busy          = emit_act_q || s1_vld_s1;
	assign s_axis_tready = !(busy && (pos_q == LAST_IDX));
	assign b             = s_axis_tdata;
	assign idx           = s_axis_tuser ? '0 : pos_q;
	assign take          = s_axis_tvalid && s_axis_tready && (s_axis_tuser || (pos_q != '0));
	assign fin           = take && (idx >= LAST_IDX);
	assign advance       = !out_vld_q || m_axis_tready;
	assign issue         = advance && emit_act_q;
	assign s1_mv         = advance && s1_vld_s1;
	assign chan_wr       = s1_mv && emit_cok_q;

	// per-byte update of crc, span and check words
	always_comb begin
		ccrc_b  = s_axis_tuser ? CRC_INIT : ccrc_q;
		scrc_b  = s_axis_tuser ? CRC_INIT : scrc_q;
		cspan_n = s_axis_tuser ? 8'd0 : cspan_q;
		sspan_n = s_axis_tuser ? 8'd0 : sspan_q;
		hm_n    = s_axis_tuser ? 2'b00 : hm_q;
		rcw0_n  = s_axis_tuser ? 16'd0 : rcw0_q;
		rcw1_n  = s_axis_tuser ? 16'd0 : rcw1_q;
		if ((idx == CTRL_HEAD_POS) && (b == sync_q)) begin
			hm_n[0] = 1'b1;
		end
		if ((idx == STAT_HEAD_POS) && (b == sync_q)) begin
			hm_n[1] = 1'b1;
		end
		if (idx == CTRL_LEN_POS) begin
			cspan_n = b;
		end
		if (idx == STAT_LEN_POS) begin
			sspan_n = b;
		end
		if (idx == CTRL_CRC_HI_POS) begin
			rcw0_n[15:8] = b;
		end
		if (idx == CTRL_CRC_LO_POS) begin
			rcw0_n[7:0] = b;
		end
		if (idx == STAT_CRC_HI_POS) begin
			rcw1_n[15:8] = b;
		end
		if (idx == STAT_CRC_LO_POS) begin
			rcw1_n[7:0] = b;
		end
		ccrc_n = ccrc_b;
		if ((idx >= CTRL_LEN_POS) && ({3'b0, idx} <= ({1'b0, cspan_n} + CTRL_SPAN_OFS))) begin
			ccrc_n = crc_step(ccrc_b, b);
		end
		scrc_n = scrc_b;
		if ((idx >= STAT_LEN_POS) && ({3'b0, idx} <= ({1'b0, sspan_n} + STAT_SPAN_OFS))) begin
			scrc_n = crc_step(scrc_b, b);
		end
		c_ok = hm_n[0] && (({1'b0, cspan_n} + CTRL_SPAN_OFS) <= {3'b0, LAST_IDX}) &&
			(ccrc_n == rcw0_n);
		s_ok = hm_n[1] && (({1'b0, sspan_n} + STAT_SPAN_OFS) <= {3'b0, LAST_IDX}) &&
			(scrc_n == rcw1_n);
	end

	// staging and channel memory addressing, channel unpacking and result value select
	always_comb begin
		wr_addr  = STG_AW'(idx - 6'd1) + (wr_bank_q ? STG_AW'(STAGE_DEPTH) : '0);
		bank_ofs = emit_bank_q ? STG_AW'(STAGE_DEPTH) : '0;
		pair     = emit_idx_q[3:1];
		rd_a     = 6'd3 + {3'b0, pair} + {2'b0, pair, 1'b0} + {5'b0, emit_idx_q[0]} + bank_ofs;
		rd_b     = rd_a + 6'd1;
		if (s1_idx_s1[0]) begin
			unpacked = {stg_a_s1[3:0], stg_b_s1};
		end else begin
			unpacked = {stg_a_s1, stg_b_s1[7:4]};
		end
		if (emit_cok_q) begin
			s1_val = unpacked;
		end else if (chan_init_s1) begin
			s1_val = chan_rd_s1;
		end else begin
			s1_val = chan_reset_value(s1_idx_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && (idx >= CTRL_LEN_POS) && (idx <= STG_LAST_POS)) begin
			stg_mem[wr_addr] <= b;
		end
		if (issue) begin
			stg_a_s1 <= stg_mem[rd_a];
			stg_b_s1 <= stg_mem[rd_b];
		end
	end

	always_ff @(posedge clk) begin
		if (chan_wr) begin
			chan_mem[s1_idx_s1] <= unpacked;
		end
		if (issue) begin
			chan_rd_s1 <= chan_mem[emit_idx_q];
		end
	end

	// pending frame bytes, read-stage index and output data, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (idx == CTRL_LEN_POS) begin
				pend_len_q <= b;
			end
			if (idx == CTRL_RSV_POS) begin
				pend_rsv_q <= b;
			end
			if (idx == CTRL_ID_POS) begin
				pend_id_q <= b;
			end
			if (idx == CTRL_FLG_POS) begin
				pend_flg_q <= b;
			end
			if (idx == RSSI_POS) begin
				pend_rssi_q <= b;
			end
		end
		if (issue) begin
			s1_idx_s1 <= emit_idx_q;
		end
		if (s1_mv) begin
			out_idx_q  <= s1_idx_s1;
			out_val_q  <= s1_val;
			out_cok_q  <= emit_cok_q;
			out_sok_q  <= emit_sok_q;
			out_flg_q  <= held_flg_q;
			out_id_q   <= held_id_q;
			out_len_q  <= held_len_q;
			out_rsv_q  <= held_rsv_q;
			out_rssi_q <= held_rssi_q;
			out_last_q <= (s1_idx_s1 == chan_idx_t'(CHANNEL_COUNT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= SYNC_RESET;
			pos_q        <= '0;
			ccrc_q       <= CRC_INIT;
			scrc_q       <= CRC_INIT;
			cspan_q      <= '0;
			sspan_q      <= '0;
			hm_q         <= '0;
			rcw0_q       <= '0;
			rcw1_q       <= '0;
			wr_bank_q    <= 1'b0;
			held_len_q   <= LEN_RESET;
			held_rsv_q   <= RSV_RESET;
			held_id_q    <= ID_RESET;
			held_flg_q   <= FLG_RESET;
			held_rssi_q  <= RSSI_RESET;
			emit_act_q   <= 1'b0;
			emit_idx_q   <= '0;
			emit_bank_q  <= 1'b0;
			emit_cok_q   <= 1'b0;
			emit_sok_q   <= 1'b0;
			chan_vld_q   <= '0;
			chan_init_s1 <= 1'b0;
			s1_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sync_q <= cfg_data;
			end
			if (take) begin
				pos_q   <= fin ? '0 : (idx + 6'd1);
				ccrc_q  <= ccrc_n;
				scrc_q  <= scrc_n;
				cspan_q <= cspan_n;
				sspan_q <= sspan_n;
				hm_q    <= hm_n;
				rcw0_q  <= rcw0_n;
				rcw1_q  <= rcw1_n;
			end
			if (fin) begin
				wr_bank_q   <= !wr_bank_q;
				emit_bank_q <= wr_bank_q;
				emit_cok_q  <= c_ok;
				emit_sok_q  <= s_ok;
				emit_act_q  <= 1'b1;
				emit_idx_q  <= '0;
				if (c_ok) begin
					held_len_q <= pend_len_q;
					held_rsv_q <= pend_rsv_q;
					held_id_q  <= pend_id_q;
					held_flg_q <= pend_flg_q;
				end
				if (s_ok) begin
					held_rssi_q <= pend_rssi_q;
				end
			end else if (issue) begin
				emit_idx_q <= emit_idx_q + 4'd1;
				if (emit_idx_q == chan_idx_t'(CHANNEL_COUNT - 1)) begin
					emit_act_q <= 1'b0;
				end
			end
			if (issue) begin
				chan_init_s1 <= chan_vld_q[emit_idx_q];
			end
			if (chan_wr) begin
				chan_vld_q[s1_idx_s1] <= 1'b1;
			end
			if (advance) begin
				s1_vld_s1 <= emit_act_q;
				out_vld_q <= s1_vld_s1;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'b0, out_rssi_q, out_rsv_q, out_len_q, out_id_q, out_flg_q,
		out_sok_q, out_cok_q, out_val_q, out_idx_q};

	// a frame never completes while the previous frame's channels are still being read
	a_no_fin_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !busy)
		else $error("frame completed during channel emission");

	// the read stage is empty when the last result leaves
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |-> !s1_vld_s1)
		else $error("channel read still pending after last result");

	// channel write-back never hits the entry being read
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_wr && issue) |-> (s1_idx_s1 != emit_idx_q))
		else $error("channel memory read and write on the same entry");

	// reads follow channel order
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && s1_vld_s1) |-> (emit_idx_q == (s1_idx_s1 + 4'd1)))
		else $error("channel reads out of order");

endmodule
`default_nettype wire
